// ===== src/tdl2_pkg.sv =====
// Shared constants and codes for the top-down level 2 metric unit.
package tdl2_pkg;

  localparam int unsigned TDL2_COUNTER_BITS = 48;
  localparam int unsigned TDL2_FRAC_BITS    = 24;
  localparam int unsigned METRIC_W          = 32;
  localparam int unsigned MUL_DIGIT_W       = 12;

  localparam logic [2:0] CMD_RETIRING   = 3'd0;
  localparam logic [2:0] CMD_BAD_SPEC   = 3'd1;
  localparam logic [2:0] CMD_FRONTEND   = 3'd2;
  localparam logic [2:0] CMD_BACKEND    = 3'd3;
  localparam logic [2:0] CMD_FETCH_LAT  = 3'd4;
  localparam logic [2:0] CMD_FETCH_BW   = 3'd5;
  localparam logic [2:0] CMD_MEM_BOUND  = 3'd6;
  localparam logic [2:0] CMD_CORE_BOUND = 3'd7;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ZERO_DEN = 2'd1;
  localparam logic [1:0] ST_SAT      = 2'd2;

endpackage

// ===== src/tdl2_if.sv =====
// Channel interfaces for counter readings and metric results.
interface tdl2_item_if import tdl2_pkg::*; #(
  parameter int unsigned COUNTER_BITS = TDL2_COUNTER_BITS
) ();
  logic                    valid;
  logic                    ready;
  logic [2:0]              cmd;
  logic [COUNTER_BITS-1:0] slots_count;
  logic [COUNTER_BITS-1:0] mem_stall_cycles;
  logic [COUNTER_BITS-1:0] total_stall_cycles;
  logic [COUNTER_BITS-1:0] store_bound_cycles;
  logic [COUNTER_BITS-1:0] recover_cycles;
  logic [COUNTER_BITS-1:0] uop_drop_count;
  logic [COUNTER_BITS-1:0] uop_undelivered_count;
  logic [COUNTER_BITS-1:0] retiring_count;
  logic [COUNTER_BITS-1:0] bad_spec_count;
  logic [COUNTER_BITS-1:0] fe_bound_count;
  logic [COUNTER_BITS-1:0] be_bound_count;

  modport source (
    output valid, cmd, slots_count, mem_stall_cycles, total_stall_cycles,
           store_bound_cycles, recover_cycles, uop_drop_count, uop_undelivered_count,
           retiring_count, bad_spec_count, fe_bound_count, be_bound_count,
    input  ready
  );
  modport sink (
    input  valid, cmd, slots_count, mem_stall_cycles, total_stall_cycles,
           store_bound_cycles, recover_cycles, uop_drop_count, uop_undelivered_count,
           retiring_count, bad_spec_count, fe_bound_count, be_bound_count,
    output ready
  );
endinterface

interface tdl2_result_if import tdl2_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [METRIC_W-1:0] metric_value;
  logic [1:0]                 status;

  modport source (output valid, metric_value, status, input ready);
  modport sink (input valid, metric_value, status, output ready);
endinterface

// ===== src/topdown_level2_metric_calc_core.sv =====
// Top-down level 1/2 metric unit: counter readings and a selector in, the selected fraction out.
//
// Channels: item_i carries a metric selector and eleven counter readings; result_o
// returns the selected fraction (signed, FRAC_BITS fractional bits) and a status
// (ok, zero denominator, saturated). Both use valid/ready; a transfer happens when
// both are high at a rising clock edge.
// Path: each item is registered in P1 and P2, passes the divider stages, E1, E2 and
// the multiplier stages, then E3, and is then written into the output queue.
// The depth of that path is set by the three restoring dividers, which retire one quotient bit
// per stage, followed by the digit-serial multiplier for the memory-bound product.
// Throughput: one item per cycle while the output queue can take results. The whole
// pipeline advances together; valid bits travel with the data so bubbles are harmless.
// Stall: a two-entry output queue holds finished results. The pipeline keeps
// moving and item_i stays ready until that queue is full and not being drained;
// nothing is dropped or repeated.
// Reset: rst_ni clears all valid bits and the output queue; no clearing pass.
module topdown_level2_metric_calc_core import tdl2_pkg::*; #(
  parameter int unsigned COUNTER_BITS = TDL2_COUNTER_BITS,
  parameter int unsigned FRAC_BITS    = TDL2_FRAC_BITS
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  tdl2_item_if.sink      item_i,
  tdl2_result_if.source  result_o
);

  localparam int unsigned CB    = COUNTER_BITS;
  localparam int unsigned DW    = CB + 2;
  localparam int unsigned NUMW  = CB + 3;
  localparam int unsigned NW    = NUMW + FRAC_BITS;
  localparam int unsigned BW    = NW + 1;
  localparam int unsigned MK    = (NW + MUL_DIGIT_W - 1) / MUL_DIGIT_W;
  localparam int unsigned FW    = MK * MUL_DIGIT_W;
  localparam int unsigned PW    = BW + FW;
  localparam int unsigned CAP_W = ((BW > METRIC_W) ? BW : METRIC_W) + 1;
  localparam int unsigned VW    = CAP_W + 2;

  typedef struct packed {
    logic [2:0] cmd;
    logic       dz;
    logic       neg;
  } side_t;

  logic adv;

  // ---------------- Stage P1: sums and selected numerator ----------------
  logic            p1_valid_q;
  logic [2:0]      p1_cmd_q;
  logic [DW-1:0]   p1_sum_q, p1_mden_q;
  logic [CB-1:0]   p1_slots_q, p1_numa_q, p1_drop_q;
  logic [NUMW-1:0] p1_nd5_q, p1_rc5_q, p1_ms_q;

  logic [DW-1:0]   sum_d, mden_d;
  logic [CB-1:0]   numa_d;
  logic [NUMW-1:0] nd5_d, rc5_d, ms_d;

  always_comb begin
    sum_d  = DW'(item_i.retiring_count) + DW'(item_i.bad_spec_count)
           + DW'(item_i.fe_bound_count) + DW'(item_i.be_bound_count);
    mden_d = DW'(item_i.total_stall_cycles) + DW'(item_i.store_bound_cycles);
    ms_d   = NUMW'(item_i.mem_stall_cycles) + NUMW'(item_i.store_bound_cycles);
    nd5_d  = (NUMW'(item_i.uop_undelivered_count) << 2)
           + NUMW'(item_i.uop_undelivered_count);
    rc5_d  = (NUMW'(item_i.recover_cycles) << 2) + NUMW'(item_i.recover_cycles);
    case (item_i.cmd)
      CMD_RETIRING:                              numa_d = item_i.retiring_count;
      CMD_BAD_SPEC:                              numa_d = item_i.bad_spec_count;
      CMD_FRONTEND, CMD_FETCH_BW:                numa_d = item_i.fe_bound_count;
      CMD_BACKEND, CMD_MEM_BOUND, CMD_CORE_BOUND: numa_d = item_i.be_bound_count;
      default:                                   numa_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_valid_q <= 1'b0;
    end else if (adv) begin
      p1_valid_q <= item_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p1_cmd_q   <= item_i.cmd;
      p1_sum_q   <= sum_d;
      p1_mden_q  <= mden_d;
      p1_slots_q <= item_i.slots_count;
      p1_numa_q  <= numa_d;
      p1_drop_q  <= item_i.uop_drop_count;
      p1_nd5_q   <= nd5_d;
      p1_rc5_q   <= rc5_d;
      p1_ms_q    <= ms_d;
    end
  end

  // ---------------- Divider pipeline, index 0 is stage P2 ----------------
  logic          dv_valid_q [NW+1];
  side_t         dv_side_q  [NW+1];
  logic [NW-1:0] dx_q       [NW+1][3];
  logic [DW-1:0] rm_q       [NW+1][3];
  logic [DW-1:0] dd_q       [NW+1][2];

  logic            ge_w, zs_w, zsl_w, zm_w, dz_w;
  logic [NUMW-1:0] mag_w, numb_w, numc_w;
  logic [DW-1:0]   denc_w;

  always_comb begin
    ge_w  = p1_nd5_q >= NUMW'(p1_drop_q);
    mag_w = ge_w ? (p1_nd5_q - NUMW'(p1_drop_q)) : (NUMW'(p1_drop_q) - p1_nd5_q);
    zs_w  = (p1_sum_q == '0);
    zsl_w = (p1_slots_q == '0);
    zm_w  = (p1_mden_q == '0);
    numb_w = '0;
    numc_w = '0;
    denc_w = p1_mden_q;
    if (p1_cmd_q inside {CMD_FRONTEND, CMD_FETCH_BW}) begin
      numb_w = NUMW'(p1_drop_q);
    end else if (p1_cmd_q inside {CMD_BACKEND, CMD_MEM_BOUND, CMD_CORE_BOUND}) begin
      numb_w = p1_rc5_q;
    end
    if (p1_cmd_q inside {CMD_FETCH_LAT, CMD_FETCH_BW}) begin
      numc_w = mag_w;
      denc_w = DW'(p1_slots_q);
    end else if (p1_cmd_q inside {CMD_MEM_BOUND, CMD_CORE_BOUND}) begin
      numc_w = p1_ms_q;
    end
    case (p1_cmd_q)
      CMD_FETCH_LAT:                 dz_w = zsl_w;
      CMD_FETCH_BW:                  dz_w = zs_w | zsl_w;
      CMD_MEM_BOUND, CMD_CORE_BOUND: dz_w = zs_w | zm_w;
      default:                       dz_w = zs_w;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_valid_q[0] <= 1'b0;
    end else if (adv) begin
      dv_valid_q[0] <= p1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dv_side_q[0] <= '{cmd: p1_cmd_q, dz: dz_w, neg: ~ge_w};
      dx_q[0][0]   <= {NUMW'(p1_numa_q), {FRAC_BITS{1'b0}}};
      dx_q[0][1]   <= {numb_w, {FRAC_BITS{1'b0}}};
      dx_q[0][2]   <= {numc_w, {FRAC_BITS{1'b0}}};
      rm_q[0][0]   <= '0;
      rm_q[0][1]   <= '0;
      rm_q[0][2]   <= '0;
      dd_q[0][0]   <= p1_sum_q;
      dd_q[0][1]   <= denc_w;
    end
  end

  // Each stage shifts one numerator bit into the remainder and one quotient bit
  // into the bottom of the same word, so after NW stages the word is the quotient.
  for (genvar k = 1; k <= NW; k++) begin : g_div
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_valid_q[k] <= 1'b0;
      end else if (adv) begin
        dv_valid_q[k] <= dv_valid_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        dv_side_q[k] <= dv_side_q[k-1];
        dd_q[k][0]   <= dd_q[k-1][0];
        dd_q[k][1]   <= dd_q[k-1][1];
      end
    end

    for (genvar u = 0; u < 3; u++) begin : g_unit
      localparam int unsigned DI = (u == 2) ? 1 : 0;
      logic [DW:0] r_sh, diff;
      logic        qb;

      always_comb begin
        r_sh = {rm_q[k-1][u], dx_q[k-1][u][NW-1]};
        diff = r_sh - {1'b0, dd_q[k-1][DI]};
        qb   = ~diff[DW];
      end

      always_ff @(posedge clk_i) begin
        if (adv) begin
          rm_q[k][u] <= qb ? diff[DW-1:0] : r_sh[DW-1:0];
          dx_q[k][u] <= {dx_q[k-1][u][NW-2:0], qb};
        end
      end
    end
  end

  // ---------------- Stage E1: level 1 combinations ----------------
  logic          e1_valid_q;
  side_t         e1_side_q;
  logic [BW-1:0] e1_fe_q, e1_be_q, e1_fl_q;
  logic [FW-1:0] e1_frac_q;
  logic [BW-1:0] qc_ext;

  assign qc_ext = {1'b0, dx_q[NW][2]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e1_valid_q <= 1'b0;
    end else if (adv) begin
      e1_valid_q <= dv_valid_q[NW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      e1_side_q <= dv_side_q[NW];
      e1_fe_q   <= {1'b0, dx_q[NW][0]} - {1'b0, dx_q[NW][1]};
      e1_be_q   <= {1'b0, dx_q[NW][0]} + {1'b0, dx_q[NW][1]};
      e1_fl_q   <= dv_side_q[NW].neg ? (~qc_ext + BW'(1)) : qc_ext;
      e1_frac_q <= FW'(dx_q[NW][2]);
    end
  end

  // ---------------- Stage E2 / multiplier index 0 ----------------
  logic          mv_valid_q [MK+1];
  side_t         mv_side_q  [MK+1];
  logic [BW-1:0] mbe_q      [MK+1];
  logic [FW-1:0] mfr_q      [MK+1];
  logic [VW-1:0] mval_q     [MK+1];
  logic [PW-1:0] macc_q     [MK+1];

  logic [BW:0]   fbw_w;
  logic [VW-1:0] val_w;

  always_comb begin
    fbw_w = {e1_fe_q[BW-1], e1_fe_q} - {e1_fl_q[BW-1], e1_fl_q};
    case (e1_side_q.cmd)
      CMD_RETIRING, CMD_BAD_SPEC, CMD_BACKEND: val_w = {{(VW-BW){1'b0}}, e1_be_q};
      CMD_FRONTEND:  val_w = {{(VW-BW){e1_fe_q[BW-1]}}, e1_fe_q};
      CMD_FETCH_LAT: val_w = {{(VW-BW){e1_fl_q[BW-1]}}, e1_fl_q};
      CMD_FETCH_BW:  val_w = fbw_w[BW] ? '0 : {{(VW-BW-1){1'b0}}, fbw_w};
      default:       val_w = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mv_valid_q[0] <= 1'b0;
    end else if (adv) begin
      mv_valid_q[0] <= e1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mv_side_q[0] <= e1_side_q;
      mbe_q[0]     <= e1_be_q;
      mfr_q[0]     <= e1_frac_q;
      mval_q[0]    <= val_w;
      macc_q[0]    <= '0;
    end
  end

  // One digit of the memory fraction per stage is multiplied into the backend value.
  for (genvar m = 1; m <= MK; m++) begin : g_mul
    logic [BW+MUL_DIGIT_W-1:0] pp;

    assign pp = mbe_q[m-1] * mfr_q[m-1][(m-1)*MUL_DIGIT_W +: MUL_DIGIT_W];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        mv_valid_q[m] <= 1'b0;
      end else if (adv) begin
        mv_valid_q[m] <= mv_valid_q[m-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        mv_side_q[m] <= mv_side_q[m-1];
        mbe_q[m]     <= mbe_q[m-1];
        mfr_q[m]     <= mfr_q[m-1];
        mval_q[m]    <= mval_q[m-1];
        macc_q[m]    <= macc_q[m-1] + (PW'(pp) << ((m-1)*MUL_DIGIT_W));
      end
    end
  end

  // ---------------- Stage E3: scale and cap the memory-bound product ----------------
  logic             e3_valid_q;
  side_t            e3_side_q;
  logic [BW-1:0]    e3_be_q;
  logic [VW-1:0]    e3_val_q;
  logic [CAP_W:0]   e3_mem_q;
  logic [PW-FRAC_BITS-1:0] mem_full;
  logic             mem_over;

  // Any product at or above the cap drives both memory and core bound to saturation,
  // so the cap value itself never shows.
  assign mem_full = macc_q[MK][PW-1:FRAC_BITS];
  assign mem_over = |mem_full[PW-FRAC_BITS-1:CAP_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e3_valid_q <= 1'b0;
    end else if (adv) begin
      e3_valid_q <= mv_valid_q[MK];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      e3_side_q <= mv_side_q[MK];
      e3_be_q   <= mbe_q[MK];
      e3_val_q  <= mval_q[MK];
      e3_mem_q  <= mem_over ? {1'b1, {CAP_W{1'b0}}} : {1'b0, mem_full[CAP_W-1:0]};
    end
  end

  // ---------------- Stage E4: final select and saturation ----------------
  logic [VW-1:0]             core_w, fin_w;
  logic [VW-METRIC_W:0]      hi_w;
  logic                      fits_w;
  logic [METRIC_W-1:0]       res_val_w;
  logic [1:0]                res_st_w;

  always_comb begin
    core_w = {{(VW-BW){1'b0}}, e3_be_q} - {{(VW-CAP_W-1){1'b0}}, e3_mem_q};
    case (e3_side_q.cmd)
      CMD_MEM_BOUND:  fin_w = {{(VW-CAP_W-1){1'b0}}, e3_mem_q};
      CMD_CORE_BOUND: fin_w = core_w;
      default:        fin_w = e3_val_q;
    endcase
    hi_w   = fin_w[VW-1:METRIC_W-1];
    fits_w = (&hi_w) | ~(|hi_w);
    if (e3_side_q.dz) begin
      res_val_w = '0;
      res_st_w  = ST_ZERO_DEN;
    end else if (!fits_w) begin
      res_val_w = fin_w[VW-1] ? {1'b1, {(METRIC_W-1){1'b0}}} : {1'b0, {(METRIC_W-1){1'b1}}};
      res_st_w  = ST_SAT;
    end else begin
      res_val_w = fin_w[METRIC_W-1:0];
      res_st_w  = ST_OK;
    end
  end

  // ---------------- Output queue ----------------
  logic [METRIC_W-1:0] fq_val_q [2];
  logic [1:0]          fq_st_q  [2];
  logic                fq_wp_q, fq_rp_q;
  logic [1:0]          fq_cnt_q;
  logic                push, pop;

  assign pop  = result_o.valid & result_o.ready;
  assign adv  = (fq_cnt_q != 2'd2) | pop;
  assign push = adv & e3_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fq_wp_q  <= 1'b0;
      fq_rp_q  <= 1'b0;
      fq_cnt_q <= 2'd0;
    end else begin
      if (push) begin
        fq_wp_q <= ~fq_wp_q;
      end
      if (pop) begin
        fq_rp_q <= ~fq_rp_q;
      end
      fq_cnt_q <= fq_cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fq_val_q[fq_wp_q] <= res_val_w;
      fq_st_q[fq_wp_q]  <= res_st_w;
    end
  end

  assign item_i.ready          = adv;
  assign result_o.valid        = (fq_cnt_q != 2'd0);
  assign result_o.metric_value = fq_val_q[fq_rp_q];
  assign result_o.status       = fq_st_q[fq_rp_q];

endmodule

// ===== src/tdl2_checker.sv =====
// Port-level assertions for the top-down metric unit, bound to the top level.
module tdl2_checker import tdl2_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_ready_i,
  input logic                res_valid_i,
  input logic                res_ready_i,
  input logic [METRIC_W-1:0] res_value_i,
  input logic [1:0]          res_status_i
);

  // A zero denominator always reports a zero value.
  a_zero_den_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_i && res_status_i == ST_ZERO_DEN) |-> (res_value_i == '0))
    else $error("zero-denominator result with nonzero value");

  // A saturated result sits at one end of the range.
  a_sat_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_i && res_status_i == ST_SAT) |->
      (res_value_i == {1'b1, {(METRIC_W-1){1'b0}}} ||
       res_value_i == {1'b0, {(METRIC_W-1){1'b1}}}))
    else $error("saturated result not at a range limit");

  // With no result waiting, the block must be able to take input.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !res_valid_i |-> in_ready_i)
    else $error("input not ready while output queue is empty");

  // A stalled result holds until its transfer.
  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_i && !res_ready_i) |=>
      (res_valid_i && $stable(res_value_i) && $stable(res_status_i)))
    else $error("result changed while stalled");

endmodule

bind topdown_level2_metric_calc_core tdl2_checker u_tdl2_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready_i   (item_i.ready),
  .res_valid_i  (result_o.valid),
  .res_ready_i  (result_o.ready),
  .res_value_i  (result_o.metric_value),
  .res_status_i (result_o.status)
);
